FILE: rtl/fomt_pkg.sv
// Package: item types, internal job type and constants of the framed OOK/Manchester transmitter.
`default_nettype none
package fomt_pkg;

	// Flag bytes that open and close a frame
	localparam logic [7:0] START_FLAG = 8'hAA;
	localparam logic [7:0] END_FLAG   = 8'h55;
	localparam logic [2:0] BIT_MSB    = 3'd7;

	// Last chip index of a byte: eight OOK chips, sixteen Manchester half-bit chips
	localparam logic [3:0] OOK_LAST_CHIP = 4'd7;
	localparam logic [3:0] MAN_LAST_CHIP = 4'd15;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_CODE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS      = 2'd1;

	// Line code selection
	localparam logic MODE_OOK        = 1'b0;
	localparam logic MODE_MANCHESTER = 1'b1;

	localparam logic [15:0] BIT_TICKS_RESET = 16'd1000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_first;
		logic       frame_last;
	} in_item_t;

	typedef struct packed {
		logic        line_level;
		logic [15:0] hold_ticks;
		logic        run_last;
		logic        frame_end;
	} out_item_t;

	// Kind of work the back end carries out for one queued job
	typedef enum logic {
		JOB_BYTE = 1'b0,
		JOB_IDLE = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;
		logic       run_last;
	} job_t;

	// Position of the front end within one input item
	typedef enum logic [1:0] {
		STEP_START = 2'd0,
		STEP_DATA  = 2'd1,
		STEP_END   = 2'd2,
		STEP_IDLE  = 2'd3
	} step_t;

endpackage
`default_nettype wire

FILE: rtl/fomt_front.sv
// Front end: accepts input items and splits each into byte and idle jobs.
`default_nettype none
module fomt_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire fomt_pkg::in_item_t in_item,
	output logic                   job_valid,
	output fomt_pkg::job_t         job,
	input  wire logic              q_full
);
	import fomt_pkg::*;

	logic       hold_q;
	logic [7:0] data_q;
	logic       last_q;
	step_t      step_q;
	step_t      step_d;
	logic       hold_d;
	logic       accept;
	logic       job_push;

	// Job for the current step
	always_comb begin
		job = '{kind: JOB_BYTE, data: data_q, run_last: 1'b0};
		unique case (step_q)
			STEP_START: begin
				job.data = START_FLAG;
			end
			STEP_DATA: begin
				job.data     = data_q;
				job.run_last = !last_q;
			end
			STEP_END: begin
				job.data = END_FLAG;
			end
			STEP_IDLE: begin
				job.kind     = JOB_IDLE;
				job.data     = '0;
				job.run_last = 1'b1;
			end
			default: begin
				job.data = data_q;
			end
		endcase
	end

	assign job_valid = hold_q;
	assign job_push  = hold_q && !q_full;
	// A new item enters in the cycle the held one posts its final job
	assign full      = hold_q && !(job_push && job.run_last);
	assign accept    = push && !full;

	// Next step
	always_comb begin
		step_d = step_q;
		hold_d = hold_q;
		priority if (accept) begin
			hold_d = 1'b1;
			step_d = in_item.frame_first ? STEP_START : STEP_DATA;
		end else if (job_push) begin
			if (job.run_last) begin
				hold_d = 1'b0;
			end else begin
				unique case (step_q)
					STEP_START: step_d = STEP_DATA;
					STEP_DATA:  step_d = STEP_END;
					STEP_END:   step_d = STEP_IDLE;
					STEP_IDLE:  step_d = STEP_IDLE;
					default:    step_d = STEP_DATA;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			step_q <= STEP_DATA;
		end else begin
			hold_q <= hold_d;
			step_q <= step_d;
		end
	end

	// Held item payload; the first mark only picks the opening step at load time
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= in_item.data_byte;
			last_q <= in_item.frame_last;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/fomt_queue.sv
// Short job queue between front and back ends.
`default_nettype none
module fomt_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire fomt_pkg::job_t wr_job,
	output logic                q_full,
	input  wire logic           rd_en,
	output fomt_pkg::job_t      rd_job,
	output logic                q_empty
);
	import fomt_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_FULL);
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_job  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/fomt_back.sv
// Back end: turns queued jobs into line chips, one per cycle, into the result register if free.
`default_nettype none
module fomt_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              line_code_mode,
	input  wire logic [15:0]       bit_ticks,
	input  wire fomt_pkg::job_t    head_job,
	input  wire logic              head_empty,
	output logic                   head_pop,
	output logic                   empty,
	input  wire logic              pop,
	output fomt_pkg::out_item_t    out_item
);
	import fomt_pkg::*;

	logic       out_valid_q;
	out_item_t  out_q;
	logic [3:0] chip_q;
	logic       advance;
	logic       last_chip;
	logic [2:0] bit_pos;
	logic       bit_val;
	out_item_t  chip;

	// Move a chip of the head job into the result register when it is free or being taken
	assign advance = !head_empty && (!out_valid_q || pop);

	// Chip of the head job
	always_comb begin
		bit_pos = (line_code_mode == MODE_MANCHESTER) ? chip_q[3:1] : chip_q[2:0];
		bit_val = head_job.data[BIT_MSB - bit_pos];
		if (head_job.kind == JOB_IDLE) begin
			last_chip       = 1'b1;
			chip.line_level = 1'b0;
			chip.hold_ticks = '0;
			chip.frame_end  = 1'b1;
		end else if (line_code_mode == MODE_MANCHESTER) begin
			last_chip       = (chip_q == MAN_LAST_CHIP);
			chip.line_level = bit_val ^ chip_q[0];
			chip.hold_ticks = bit_ticks >> 1;
			chip.frame_end  = 1'b0;
		end else begin
			last_chip       = (chip_q == OOK_LAST_CHIP);
			chip.line_level = bit_val;
			chip.hold_ticks = bit_ticks;
			chip.frame_end  = 1'b0;
		end
		chip.run_last = last_chip && head_job.run_last;
	end

	assign head_pop = advance && last_chip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			chip_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				chip_q      <= last_chip ? '0 : chip_q + 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= chip;
		end
	end

	assign empty    = !out_valid_q;
	assign out_item = out_q;

endmodule
`default_nettype wire

FILE: rtl/framed_ook_manchester_transmitter.sv
// Top level of the framed OOK/Manchester transmitter: configuration registers and the three parts.
`default_nettype none
// Each input item is one payload byte with first/last frame marks. A first byte is sent after
// the start flag 0xAA; a last byte is followed by the end flag 0x55 and one idle-low chip with
// zero hold. Bytes go out MSB first, one chip per result item: eight chips per byte in OOK mode,
// sixteen half-bit chips in Manchester mode. The back end produces one chip per cycle while a job
// is queued and the result register is empty or being popped; that chip loop sets the rate. The
// front end splits items into byte and idle jobs through a QUEUE_DEPTH entry queue and takes the
// next item as soon as its last job is queued.
// Configuration (index 0 line code mode, index 1 bit ticks) is to be written while idle;
// writes are always ready and other indexes are ignored.
module framed_ook_manchester_transmitter #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire fomt_pkg::in_item_t                  in_item,
	output logic                                     empty,
	input  wire logic                                pop,
	output fomt_pkg::out_item_t                      out_item,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [fomt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [15:0]                         cfg_data
);
	import fomt_pkg::*;

	logic        line_code_mode_q;
	logic [15:0] bit_ticks_q;
	logic        job_valid;
	job_t        front_job;
	logic        q_full;
	job_t        head_job;
	logic        head_empty;
	logic        head_pop;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_code_mode_q <= MODE_OOK;
			bit_ticks_q      <= BIT_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_LINE_CODE_MODE) begin
				line_code_mode_q <= cfg_data[0];
			end else if (cfg_index == CFG_BIT_TICKS) begin
				bit_ticks_q <= cfg_data;
			end
		end
	end

	fomt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.job_valid (job_valid),
		.job       (front_job),
		.q_full    (q_full)
	);

	fomt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_job  (front_job),
		.q_full  (q_full),
		.rd_en   (head_pop),
		.rd_job  (head_job),
		.q_empty (head_empty)
	);

	fomt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.line_code_mode (line_code_mode_q),
		.bit_ticks      (bit_ticks_q),
		.head_job       (head_job),
		.head_empty     (head_empty),
		.head_pop       (head_pop),
		.empty          (empty),
		.pop            (pop),
		.out_item       (out_item)
	);

endmodule
`default_nettype wire
